// ===== design/i2cbm_pkg.sv =====
// Shared constants for the tick-stepped I2C bit-level master.
package i2cbm_pkg;

  // Default width of the delay counter
  localparam int unsigned DelayCountWidth = 16;

  // Configuration register widths and indexes
  localparam int unsigned DelayTicksWidth = 16;
  localparam int unsigned AckTimeoutWidth = 8;
  localparam int unsigned CfgDataWidth    = 16;
  localparam int unsigned CfgIdxWidth     = 1;

  localparam logic [CfgIdxWidth-1:0] CfgDelayTicks = 1'd0;
  localparam logic [CfgIdxWidth-1:0] CfgAckTimeout = 1'd1;

  localparam logic [DelayTicksWidth-1:0] DelayTicksRst = 16'd100;
  localparam logic [AckTimeoutWidth-1:0] AckTimeoutRst = 8'd250;

  // Command codes
  localparam logic [2:0] FuncStart    = 3'd0;
  localparam logic [2:0] FuncStop     = 3'd1;
  localparam logic [2:0] FuncWrite    = 3'd2;
  localparam logic [2:0] FuncRead     = 3'd3;
  localparam logic [2:0] FuncWaitAck  = 3'd4;
  localparam logic [2:0] FuncSendAck  = 3'd5;
  localparam logic [2:0] FuncSendNack = 3'd6;
  localparam logic [2:0] FuncNone     = 3'd7;

  // Stream widths
  localparam int unsigned InDataWidth  = 16;
  localparam int unsigned InUserWidth  = 4;
  localparam int unsigned OutDataWidth = 16;

  // Bits per byte on the bus
  localparam logic [3:0] BitsPerByte = 4'd8;

endpackage

// ===== design/i2c_bit_level_master.sv =====
// Tick-stepped I2C master: sequencer state, pin registers and result skid buffer.
//
// Each transfer on the slave stream is one bus tick. tuser carries the command
// flag and code, tdata the write byte, the ack choice for read byte and the
// sampled SDA level. Every accepted tick yields exactly one result transfer on
// the master stream with the SCL/SDA drive levels, SDA direction, busy, done,
// the last read byte and the last wait-ack outcome.
// A tick is accepted in any cycle in which the slave tready is high, so the
// block takes one tick per clock while tready is high. Each result is registered
// in the output register, or in the skid register while an older result waits;
// this two-entry output buffer lets a tick be taken while one result still
// waits; when both are full, slave tready drops until the receiver takes a result.
// A command is taken only on a tick whose previous result showed busy low;
// commands arriving while busy, and code seven, are ignored.
// Configuration (delay ticks, ack timeout) is to be written through cfg_we_i only
// while idle, which the block does not check; a write takes effect at the next clock edge.
// Reset (rst_ni low) releases SCL and SDA high in output mode, empties the
// output buffer and loads delay ticks 100 and ack timeout 250.
module i2c_bit_level_master #(
  parameter int unsigned DELAY_COUNT_WIDTH = i2cbm_pkg::DelayCountWidth
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write port
  input  logic                                  cfg_we_i,
  input  logic [i2cbm_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [i2cbm_pkg::CfgDataWidth-1:0]    cfg_wdata_i,
  // tick stream in
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [7:0] write_data, [8] send_ack, [9] sda_in, [15:10] zero
  input  logic [i2cbm_pkg::InDataWidth-1:0]     s_axis_tdata_i,
  // [0] cmd_valid, [3:1] func
  input  logic [i2cbm_pkg::InUserWidth-1:0]     s_axis_tuser_i,
  // result stream out
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // [0] scl_level, [1] sda_level, [2] sda_output_mode, [3] busy_res, [4] done_res,
  // [12:5] read_value, [13] ack_seen, [15:14] zero
  output logic [i2cbm_pkg::OutDataWidth-1:0]    m_axis_tdata_o
);

  localparam int unsigned DcW = DELAY_COUNT_WIDTH;

  // Sequencer phase codes
  localparam logic [4:0] PhIdle = 5'd0;
  localparam logic [4:0] PhSt0  = 5'd1;
  localparam logic [4:0] PhSt1  = 5'd2;
  localparam logic [4:0] PhSt2  = 5'd3;
  localparam logic [4:0] PhSt3  = 5'd4;
  localparam logic [4:0] PhSp0  = 5'd5;
  localparam logic [4:0] PhSp1  = 5'd6;
  localparam logic [4:0] PhSp2  = 5'd7;
  localparam logic [4:0] PhWr0  = 5'd8;
  localparam logic [4:0] PhWr1  = 5'd9;
  localparam logic [4:0] PhWr2  = 5'd10;
  localparam logic [4:0] PhWr3  = 5'd11;
  localparam logic [4:0] PhRd0  = 5'd12;
  localparam logic [4:0] PhRd1  = 5'd13;
  localparam logic [4:0] PhAk0  = 5'd14;
  localparam logic [4:0] PhAk1  = 5'd15;
  localparam logic [4:0] PhAk2  = 5'd16;
  localparam logic [4:0] PhWa0  = 5'd17;
  localparam logic [4:0] PhWa1  = 5'd18;
  localparam logic [4:0] PhWa2  = 5'd19;
  localparam logic [4:0] PhWa3  = 5'd20;

  // configuration
  logic [i2cbm_pkg::DelayTicksWidth-1:0] delay_ticks_q;
  logic [i2cbm_pkg::AckTimeoutWidth-1:0] ack_timeout_q;

  // sequencer state
  logic [4:0]     phase_q, phase_d;
  logic [3:0]     bit_cnt_q, bit_cnt_d;
  logic [7:0]     shift_q, shift_d;
  logic [DcW-1:0] dly_cnt_q, dly_cnt_d;
  logic [7:0]     poll_cnt_q, poll_cnt_d;
  logic           ack_after_rd_q, ack_after_rd_d;
  logic           scl_q, scl_d;
  logic           sda_q, sda_d;
  logic           oe_q, oe_d;
  logic           ack_res_q, ack_res_d;
  logic [7:0]     rd_latch_q, rd_latch_d;
  logic           done_d;
  logic           busy_d;
  logic           run_grp;

  // input fields
  logic       in_cmd_valid;
  logic [2:0] in_func;
  logic [7:0] in_wdata;
  logic       in_send_ack;
  logic       in_sda;

  logic [31:0]    dly_ext;
  logic [DcW-1:0] dly_masked;
  logic [DcW-1:0] dly_reload;

  // output buffer
  logic                                   out_valid_q, skid_valid_q;
  logic [i2cbm_pkg::OutDataWidth-1:0]     out_q, skid_q, res_data;
  logic                                   in_xfer, out_pop;

  assign in_cmd_valid = s_axis_tuser_i[0];
  assign in_func      = s_axis_tuser_i[3:1];
  assign in_wdata     = s_axis_tdata_i[7:0];
  assign in_send_ack  = s_axis_tdata_i[8];
  assign in_sda       = s_axis_tdata_i[9];

  assign dly_ext    = 32'(delay_ticks_q);
  assign dly_masked = dly_ext[DcW-1:0];
  // a zero delay still lasts one tick
  assign dly_reload = (dly_masked == '0) ? '0 : dly_masked - DcW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_ticks_q <= i2cbm_pkg::DelayTicksRst;
      ack_timeout_q <= i2cbm_pkg::AckTimeoutRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == i2cbm_pkg::CfgDelayTicks) begin
        delay_ticks_q <= cfg_wdata_i[i2cbm_pkg::DelayTicksWidth-1:0];
      end else if (cfg_idx_i == i2cbm_pkg::CfgAckTimeout) begin
        ack_timeout_q <= cfg_wdata_i[i2cbm_pkg::AckTimeoutWidth-1:0];
      end
    end
  end

  always_comb begin
    phase_d        = phase_q;
    bit_cnt_d      = bit_cnt_q;
    shift_d        = shift_q;
    dly_cnt_d      = dly_cnt_q;
    poll_cnt_d     = poll_cnt_q;
    ack_after_rd_d = ack_after_rd_q;
    scl_d          = scl_q;
    sda_d          = sda_q;
    oe_d           = oe_q;
    ack_res_d      = ack_res_q;
    rd_latch_d     = rd_latch_q;
    done_d         = 1'b0;
    run_grp        = 1'b0;

    if (phase_q == PhIdle) begin
      if (in_cmd_valid && (in_func != i2cbm_pkg::FuncNone)) begin
        bit_cnt_d  = '0;
        poll_cnt_d = '0;
        dly_cnt_d  = '0;
        run_grp    = 1'b1;
        case (in_func)
          i2cbm_pkg::FuncStart:   phase_d = PhSt0;
          i2cbm_pkg::FuncStop:    phase_d = PhSp0;
          i2cbm_pkg::FuncWrite: begin
            shift_d = in_wdata;
            phase_d = PhWr0;
          end
          i2cbm_pkg::FuncRead: begin
            shift_d        = '0;
            ack_after_rd_d = in_send_ack;
            phase_d        = PhRd0;
          end
          i2cbm_pkg::FuncWaitAck: phase_d = PhWa0;
          i2cbm_pkg::FuncSendAck: begin
            ack_after_rd_d = 1'b1;
            phase_d        = PhAk0;
          end
          default: begin
            ack_after_rd_d = 1'b0;
            phase_d        = PhAk0;
          end
        endcase
      end
    end else if (dly_cnt_q != '0) begin
      dly_cnt_d = dly_cnt_q - DcW'(1);
    end else begin
      run_grp = 1'b1;
    end

    if (run_grp) begin
      case (phase_d)
        PhSt0: begin
          oe_d = 1'b1; sda_d = 1'b1; scl_d = 1'b1;
          dly_cnt_d = dly_reload; phase_d = PhSt1;
        end
        PhSt1: begin sda_d = 1'b0; dly_cnt_d = dly_reload; phase_d = PhSt2; end
        PhSt2: begin scl_d = 1'b0; dly_cnt_d = dly_reload; phase_d = PhSt3; end
        PhSp0: begin
          oe_d = 1'b1; sda_d = 1'b0; scl_d = 1'b1;
          dly_cnt_d = dly_reload; phase_d = PhSp1;
        end
        PhSp1: begin sda_d = 1'b1; dly_cnt_d = dly_reload; phase_d = PhSp2; end
        PhWr0: begin
          if (bit_cnt_d == '0) begin
            oe_d  = 1'b1;
            scl_d = 1'b0;
          end
          sda_d     = shift_d[7];
          shift_d   = {shift_d[6:0], 1'b0};
          dly_cnt_d = dly_reload;
          phase_d   = PhWr1;
        end
        PhWr1: begin scl_d = 1'b1; dly_cnt_d = dly_reload; phase_d = PhWr2; end
        PhWr2: begin
          scl_d     = 1'b0;
          bit_cnt_d = bit_cnt_d + 4'd1;
          dly_cnt_d = dly_reload;
          phase_d   = (bit_cnt_d >= i2cbm_pkg::BitsPerByte) ? PhWr3 : PhWr0;
        end
        PhRd0: begin
          if (bit_cnt_d == '0) oe_d = 1'b0;
          scl_d     = 1'b0;
          dly_cnt_d = dly_reload;
          phase_d   = PhRd1;
        end
        PhRd1: begin
          scl_d     = 1'b1;
          shift_d   = {shift_d[6:0], in_sda};
          bit_cnt_d = bit_cnt_d + 4'd1;
          dly_cnt_d = dly_reload;
          if (bit_cnt_d >= i2cbm_pkg::BitsPerByte) begin
            rd_latch_d = shift_d;
            phase_d    = PhAk0;
          end else begin
            phase_d = PhRd0;
          end
        end
        PhAk0: begin
          scl_d = 1'b0; oe_d = 1'b1; sda_d = ~ack_after_rd_d;
          dly_cnt_d = dly_reload; phase_d = PhAk1;
        end
        PhAk1: begin scl_d = 1'b1; dly_cnt_d = dly_reload; phase_d = PhAk2; end
        PhAk2: begin
          scl_d = 1'b0; sda_d = 1'b1;
          done_d = 1'b1; phase_d = PhIdle;
        end
        PhWa0: begin
          oe_d = 1'b0; sda_d = 1'b1;
          dly_cnt_d = dly_reload; phase_d = PhWa1;
        end
        PhWa1: begin scl_d = 1'b1; dly_cnt_d = dly_reload; phase_d = PhWa2; end
        PhWa2: begin
          if (!in_sda) begin
            ack_res_d = 1'b1;
            scl_d     = 1'b0;
            dly_cnt_d = dly_reload;
            phase_d   = PhWa3;
          end else if (poll_cnt_d >= ack_timeout_q) begin
            // timed out: drive the stop condition from this tick
            ack_res_d = 1'b0;
            oe_d = 1'b1; sda_d = 1'b0; scl_d = 1'b1;
            dly_cnt_d = dly_reload;
            phase_d   = PhSp1;
          end else begin
            poll_cnt_d = poll_cnt_d + 8'd1;
          end
        end
        PhSt3, PhSp2, PhWr3, PhWa3: begin
          done_d  = 1'b1;
          phase_d = PhIdle;
        end
        default: phase_d = PhIdle;
      endcase
    end

    busy_d = (phase_d != PhIdle);
  end

  assign res_data = {2'b00, ack_res_d, rd_latch_d, done_d, busy_d, oe_d, sda_d, scl_d};

  assign s_axis_tready_o = ~skid_valid_q;
  assign in_xfer         = s_axis_tvalid_i & ~skid_valid_q;
  assign out_pop         = out_valid_q & m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhIdle;
      bit_cnt_q      <= '0;
      shift_q        <= '0;
      dly_cnt_q      <= '0;
      poll_cnt_q     <= '0;
      ack_after_rd_q <= 1'b0;
      scl_q          <= 1'b1;
      sda_q          <= 1'b1;
      oe_q           <= 1'b1;
      ack_res_q      <= 1'b0;
      rd_latch_q     <= '0;
    end else if (in_xfer) begin
      phase_q        <= phase_d;
      bit_cnt_q      <= bit_cnt_d;
      shift_q        <= shift_d;
      dly_cnt_q      <= dly_cnt_d;
      poll_cnt_q     <= poll_cnt_d;
      ack_after_rd_q <= ack_after_rd_d;
      scl_q          <= scl_d;
      sda_q          <= sda_d;
      oe_q           <= oe_d;
      ack_res_q      <= ack_res_d;
      rd_latch_q     <= rd_latch_d;
    end
  end

  // output register plus skid register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_pop) skid_valid_q <= 1'b0;
    end else if (in_xfer) begin
      if (out_valid_q && !out_pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) out_q <= skid_q;
    end else if (in_xfer) begin
      if (out_valid_q && !out_pop) begin
        skid_q <= res_data;
      end else begin
        out_q <= res_data;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

// ===== tb/i2c_bit_level_master_test.sv =====
// Self-checking testbench for the tick-stepped I2C bit-level master.
`timescale 1ns / 1ps

module i2c_bit_level_master_test;

  localparam int unsigned StallLimit = 2000;

  // sda choices for the ticks of one command
  localparam int SdaAllLow  = -3;
  localparam int SdaRandom  = -2;
  localparam int SdaAllHigh = -1;

  typedef enum logic [4:0] {
    PhIdle, PhStartDrive, PhStartSdaLow, PhStartSclLow, PhStartDone,
    PhStopDrive, PhStopSdaHigh, PhStopDone,
    PhWrBit, PhWrSclHigh, PhWrSclLow, PhWrDone,
    PhRdSclLow, PhRdSample,
    PhAckDrive, PhAckSclHigh, PhAckSclLow,
    PhWaRelease, PhWaSclHigh, PhWaPoll, PhWaDone
  } bus_phase_e;

  typedef struct {
    logic       scl;
    logic       sda;
    logic       oe;
    logic       busy;
    logic       done;
    logic [7:0] rd;
    logic       ack;
  } pin_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [i2cbm_pkg::CfgIdxWidth-1:0] cfg_idx_i = '0;
  logic [i2cbm_pkg::CfgDataWidth-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  // [7:0] write_data, [8] send_ack, [9] sda_in, [15:10] zero
  logic [i2cbm_pkg::InDataWidth-1:0] s_axis_tdata_i = '0;
  // [0] cmd_valid, [3:1] func
  logic [i2cbm_pkg::InUserWidth-1:0] s_axis_tuser_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  // [0] scl_level, [1] sda_level, [2] sda_output_mode, [3] busy_res, [4] done_res,
  // [12:5] read_value, [13] ack_seen, [15:14] zero
  logic [i2cbm_pkg::OutDataWidth-1:0] m_axis_tdata_o;

  // bus model state
  logic [15:0] cfg_delay;
  logic [7:0]  cfg_timeout;
  bus_phase_e  bus_phase;
  logic [3:0]  bits_done;
  logic [7:0]  byte_sr;
  logic [15:0] wait_left;
  logic [7:0]  polls;
  logic        ack_reply;
  logic        scl_q, sda_q, oe_q;
  logic        ack_flag;
  logic [7:0]  rd_byte;
  logic        done_q;

  pin_result_t pending_pins[$];
  bit          idle_en = 1'b1;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned results_checked = 0;
  int unsigned live_ticks = 0;
  int unsigned cmds_run = 0;
  int unsigned cfg_writes = 0;

  i2c_bit_level_master u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- bus model

  function automatic void arm_delay(input bus_phase_e nxt);
    wait_left = (cfg_delay == 16'd0) ? 16'd0 : cfg_delay - 16'd1;
    bus_phase = nxt;
  endfunction

  function automatic void run_pin_group(input logic sda_bit);
    case (bus_phase)
      PhStartDrive: begin
        oe_q = 1'b1; sda_q = 1'b1; scl_q = 1'b1;
        arm_delay(PhStartSdaLow);
      end
      PhStartSdaLow: begin
        sda_q = 1'b0;
        arm_delay(PhStartSclLow);
      end
      PhStartSclLow: begin
        scl_q = 1'b0;
        arm_delay(PhStartDone);
      end
      PhStopDrive: begin
        oe_q = 1'b1; sda_q = 1'b0; scl_q = 1'b1;
        arm_delay(PhStopSdaHigh);
      end
      PhStopSdaHigh: begin
        sda_q = 1'b1;
        arm_delay(PhStopDone);
      end
      PhWrBit: begin
        if (bits_done == 4'd0) begin
          oe_q = 1'b1; scl_q = 1'b0;
        end
        sda_q = byte_sr[7];
        byte_sr = {byte_sr[6:0], 1'b0};
        arm_delay(PhWrSclHigh);
      end
      PhWrSclHigh: begin
        scl_q = 1'b1;
        arm_delay(PhWrSclLow);
      end
      PhWrSclLow: begin
        scl_q = 1'b0;
        bits_done = bits_done + 4'd1;
        arm_delay(bits_done >= i2cbm_pkg::BitsPerByte ? PhWrDone : PhWrBit);
      end
      PhRdSclLow: begin
        if (bits_done == 4'd0) oe_q = 1'b0;
        scl_q = 1'b0;
        arm_delay(PhRdSample);
      end
      PhRdSample: begin
        scl_q = 1'b1;
        byte_sr = {byte_sr[6:0], sda_bit};
        bits_done = bits_done + 4'd1;
        if (bits_done >= i2cbm_pkg::BitsPerByte) begin
          rd_byte = byte_sr;
          arm_delay(PhAckDrive);
        end else begin
          arm_delay(PhRdSclLow);
        end
      end
      PhAckDrive: begin
        scl_q = 1'b0; oe_q = 1'b1; sda_q = !ack_reply;
        arm_delay(PhAckSclHigh);
      end
      PhAckSclHigh: begin
        scl_q = 1'b1;
        arm_delay(PhAckSclLow);
      end
      PhAckSclLow: begin
        scl_q = 1'b0; sda_q = 1'b1;
        done_q = 1'b1; bus_phase = PhIdle;
      end
      PhWaRelease: begin
        oe_q = 1'b0; sda_q = 1'b1;
        arm_delay(PhWaSclHigh);
      end
      PhWaSclHigh: begin
        scl_q = 1'b1;
        arm_delay(PhWaPoll);
      end
      PhWaPoll: begin
        if (!sda_bit) begin
          ack_flag = 1'b1;
          scl_q = 1'b0;
          arm_delay(PhWaDone);
        end else if (polls >= cfg_timeout) begin
          // give up: drive a stop from here
          ack_flag = 1'b0;
          oe_q = 1'b1; sda_q = 1'b0; scl_q = 1'b1;
          arm_delay(PhStopSdaHigh);
        end else begin
          polls = polls + 8'd1;
        end
      end
      PhStartDone, PhStopDone, PhWrDone, PhWaDone: begin
        done_q = 1'b1; bus_phase = PhIdle;
      end
      default: bus_phase = PhIdle;
    endcase
  endfunction

  function automatic pin_result_t bus_tick(input logic cmd_v, input logic [2:0] code,
                                           input logic [7:0] wd, input logic sack,
                                           input logic sda_bit);
    pin_result_t r;
    done_q = 1'b0;
    if (bus_phase == PhIdle) begin
      if (cmd_v && code != i2cbm_pkg::FuncNone) begin
        live_ticks++;
        bits_done = 4'd0;
        polls = 8'd0;
        wait_left = 16'd0;
        case (code)
          i2cbm_pkg::FuncStart:   bus_phase = PhStartDrive;
          i2cbm_pkg::FuncStop:    bus_phase = PhStopDrive;
          i2cbm_pkg::FuncWrite: begin
            byte_sr = wd; bus_phase = PhWrBit;
          end
          i2cbm_pkg::FuncRead: begin
            byte_sr = 8'd0; ack_reply = sack; bus_phase = PhRdSclLow;
          end
          i2cbm_pkg::FuncWaitAck: bus_phase = PhWaRelease;
          i2cbm_pkg::FuncSendAck: begin
            ack_reply = 1'b1; bus_phase = PhAckDrive;
          end
          default: begin
            ack_reply = 1'b0; bus_phase = PhAckDrive;
          end
        endcase
        run_pin_group(sda_bit);
      end
    end else begin
      live_ticks++;
      if (wait_left != 16'd0) wait_left = wait_left - 16'd1;
      else run_pin_group(sda_bit);
    end
    r.scl = scl_q;
    r.sda = sda_q;
    r.oe = oe_q;
    r.busy = (bus_phase != PhIdle);
    r.done = done_q;
    r.rd = rd_byte;
    r.ack = ack_flag;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    pin_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pending_pins.size() == 0) begin
          $error("result transfer with nothing expected: tdata %0h", m_axis_tdata_o);
          mismatches++;
        end else begin
          want = pending_pins.pop_front();
          results_checked++;
          check_field("scl_level", want.scl, m_axis_tdata_o[0]);
          check_field("sda_level", want.sda, m_axis_tdata_o[1]);
          check_field("sda_output_mode", want.oe, m_axis_tdata_o[2]);
          check_field("busy_res", want.busy, m_axis_tdata_o[3]);
          check_field("done_res", want.done, m_axis_tdata_o[4]);
          check_field("read_value", want.rd, m_axis_tdata_o[12:5]);
          check_field("ack_seen", want.ack, m_axis_tdata_o[13]);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        pending_pins.push_back(bus_tick(s_axis_tuser_i[0], s_axis_tuser_i[3:1],
                                        s_axis_tdata_i[7:0], s_axis_tdata_i[8],
                                        s_axis_tdata_i[9]));
      end
    end
  end

  // receiver stalls in bursts
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left <= $urandom_range(0, 14);
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("no transfer for %0d cycles", StallLimit);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  // Enter and leave at a falling edge.
  task automatic send_tick(input logic cmd_v, input logic [2:0] code, input logic [7:0] wd,
                           input logic sack, input logic sda_bit);
    if (idle_en && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= {code, cmd_v};
    s_axis_tdata_i <= {6'd0, sda_bit, sack, wd};
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  // SDA level for the next tick, given the current model state
  function automatic logic pick_sda(input int plan);
    if (plan == SdaAllLow) return 1'b0;
    if (plan == SdaAllHigh) return 1'b1;
    if (plan >= 0 && bus_phase == PhWaPoll && wait_left == 16'd0)
      return (polls >= plan) ? 1'b0 : 1'b1;
    return 1'($urandom);
  endfunction

  // Offer one command, then tick (with ignored noise commands) until it ends.
  task automatic run_cmd(input logic [2:0] code, input logic [7:0] wd, input logic sack,
                         input int plan);
    logic noisy;
    send_tick(1'b1, code, wd, sack, pick_sda(plan));
    cmds_run++;
    while (bus_phase != PhIdle) begin
      noisy = ($urandom_range(0, 3) == 0);
      send_tick(noisy, 3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                pick_sda(plan));
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending_pins.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_reg(input logic [i2cbm_pkg::CfgIdxWidth-1:0] idx,
                         input logic [i2cbm_pkg::CfgDataWidth-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    if (idx == i2cbm_pkg::CfgDelayTicks) cfg_delay = value;
    else cfg_timeout = value[7:0];
    cfg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic int ack_plan();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 3);
      6, 7:             return $urandom_range(0, cfg_timeout + 1);
      8:                return SdaAllHigh;
      default:          return SdaRandom;
    endcase
  endfunction

  task automatic random_transaction();
    if ($urandom_range(0, 5) == 0) begin
      // loose commands, including the unused code and idle ticks
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 2) == 0)
          send_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                    1'($urandom));
        else
          run_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), SdaRandom);
      end
    end else begin
      run_cmd(i2cbm_pkg::FuncStart, 8'($urandom), 1'($urandom), SdaRandom);
      run_cmd(i2cbm_pkg::FuncWrite, 8'($urandom), 1'($urandom), SdaRandom);
      run_cmd(i2cbm_pkg::FuncWaitAck, 8'($urandom), 1'($urandom), ack_plan());
      if (ack_flag) begin
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(0, 1) == 0) begin
            run_cmd(i2cbm_pkg::FuncWrite, 8'($urandom), 1'($urandom), SdaRandom);
            run_cmd(i2cbm_pkg::FuncWaitAck, 8'($urandom), 1'($urandom), ack_plan());
          end else begin
            run_cmd(i2cbm_pkg::FuncRead, 8'($urandom), 1'($urandom), SdaRandom);
          end
        end
        if ($urandom_range(0, 7) == 0)
          run_cmd($urandom_range(0, 1) ? i2cbm_pkg::FuncSendAck : i2cbm_pkg::FuncSendNack,
                  8'($urandom), 1'($urandom), SdaRandom);
      end
      // now and then leave the bus without a stop
      if ($urandom_range(0, 7) != 0)
        run_cmd(i2cbm_pkg::FuncStop, 8'($urandom), 1'($urandom), SdaRandom);
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_state();
    send_tick(1'b0, i2cbm_pkg::FuncStart, 8'd0, 1'b0, 1'b0);
    send_tick(1'b1, i2cbm_pkg::FuncNone, 8'hFF, 1'b1, 1'b1);
    run_cmd(i2cbm_pkg::FuncStart, 8'd0, 1'b0, SdaRandom);
  endtask

  task automatic test_each_command();
    drain_results();
    set_reg(i2cbm_pkg::CfgDelayTicks, 16'd1);
    set_reg(i2cbm_pkg::CfgAckTimeout, 16'd3);
    run_cmd(i2cbm_pkg::FuncStart, 8'h00, 1'b0, SdaRandom);
    run_cmd(i2cbm_pkg::FuncWrite, 8'h00, 1'b0, SdaRandom);
    run_cmd(i2cbm_pkg::FuncWaitAck, 8'h00, 1'b0, 0);
    run_cmd(i2cbm_pkg::FuncWrite, 8'hFF, 1'b1, SdaRandom);
    run_cmd(i2cbm_pkg::FuncWaitAck, 8'h00, 1'b0, 2);
    run_cmd(i2cbm_pkg::FuncRead, 8'h00, 1'b1, SdaAllHigh);
    run_cmd(i2cbm_pkg::FuncRead, 8'hFF, 1'b0, SdaAllLow);
    run_cmd(i2cbm_pkg::FuncSendAck, 8'h00, 1'b0, SdaRandom);
    run_cmd(i2cbm_pkg::FuncSendNack, 8'h00, 1'b1, SdaRandom);
    run_cmd(i2cbm_pkg::FuncWaitAck, 8'h00, 1'b0, SdaAllHigh);
    run_cmd(i2cbm_pkg::FuncStart, 8'h00, 1'b0, SdaRandom);
    run_cmd(i2cbm_pkg::FuncRead, 8'h00, 1'b1, SdaRandom);
    run_cmd(i2cbm_pkg::FuncStop, 8'h00, 1'b0, SdaRandom);
    run_cmd(i2cbm_pkg::FuncNone, 8'h5A, 1'b1, SdaRandom);
  endtask

  task automatic test_zero_delay();
    drain_results();
    set_reg(i2cbm_pkg::CfgDelayTicks, 16'd0);
    run_cmd(i2cbm_pkg::FuncStart, 8'h00, 1'b0, SdaRandom);
    run_cmd(i2cbm_pkg::FuncWrite, 8'hA5, 1'b0, SdaRandom);
    run_cmd(i2cbm_pkg::FuncWaitAck, 8'h00, 1'b0, 1);
    run_cmd(i2cbm_pkg::FuncStop, 8'h00, 1'b0, SdaRandom);
  endtask

  task automatic test_ack_timeout_limits();
    drain_results();
    set_reg(i2cbm_pkg::CfgDelayTicks, 16'd2);
    // upper data bits do not reach the 8-bit register
    set_reg(i2cbm_pkg::CfgAckTimeout, 16'hFF00);
    run_cmd(i2cbm_pkg::FuncWaitAck, 8'h00, 1'b0, SdaAllHigh);
    run_cmd(i2cbm_pkg::FuncWaitAck, 8'h00, 1'b0, 0);
    drain_results();
    set_reg(i2cbm_pkg::CfgAckTimeout, 16'hFFFF);
    run_cmd(i2cbm_pkg::FuncWaitAck, 8'h00, 1'b0, SdaAllHigh);
    run_cmd(i2cbm_pkg::FuncWaitAck, 8'h00, 1'b0, 255);
  endtask

  task automatic test_long_delay();
    drain_results();
    idle_en = 1'b0;
    set_reg(i2cbm_pkg::CfgDelayTicks, 16'd40);
    run_cmd(i2cbm_pkg::FuncStop, 8'h00, 1'b0, SdaRandom);
    idle_en = 1'b1;
  endtask

  task automatic test_random_traffic();
    int unsigned base;
    base = live_ticks;
    while (live_ticks - base < 150) begin
      if ($urandom_range(0, 2) == 0) begin
        drain_results();
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: set_reg(i2cbm_pkg::CfgDelayTicks, 16'($urandom_range(1, 3)));
          6, 7:             set_reg(i2cbm_pkg::CfgDelayTicks, 16'($urandom_range(4, 8)));
          8:                set_reg(i2cbm_pkg::CfgDelayTicks, 16'd0);
          default:          set_reg(i2cbm_pkg::CfgDelayTicks, 16'd1);
        endcase
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6:
            set_reg(i2cbm_pkg::CfgAckTimeout, {8'($urandom), 8'($urandom_range(0, 6))});
          7:       set_reg(i2cbm_pkg::CfgAckTimeout, {8'($urandom), 8'd0});
          8:       set_reg(i2cbm_pkg::CfgAckTimeout, {8'($urandom), 8'd255});
          default: set_reg(i2cbm_pkg::CfgAckTimeout, 16'($urandom));
        endcase
      end
      idle_en = ($urandom_range(0, 3) != 0);
      random_transaction();
    end
    idle_en = 1'b1;
  endtask

  task automatic test_steady_tail();
    int unsigned base;
    drain_results();
    idle_en = 1'b0;
    base = live_ticks;
    while (live_ticks - base < 150) random_transaction();
  endtask

  initial begin
    cfg_delay = i2cbm_pkg::DelayTicksRst;
    cfg_timeout = i2cbm_pkg::AckTimeoutRst;
    bus_phase = PhIdle;
    bits_done = 4'd0;
    byte_sr = 8'd0;
    wait_left = 16'd0;
    polls = 8'd0;
    ack_reply = 1'b0;
    scl_q = 1'b1;
    sda_q = 1'b1;
    oe_q = 1'b1;
    ack_flag = 1'b0;
    rd_byte = 8'd0;
    done_q = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_each_command();
    test_zero_delay();
    test_ack_timeout_limits();
    test_long_delay();
    test_random_traffic();
    test_steady_tail();

    drain_results();
    repeat (8) @(negedge clk_i);
    $display("Ran %0d bus ticks in %0d commands across %0d register writes,",
             live_ticks, cmds_run, cfg_writes);
    $display("delays 0..100 and ack timeouts 0..255; %0d results compared.",
             results_checked);
    if (mismatches == 0 && pending_pins.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
